>>> design/estm_pkg.sv
package estm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  localparam int CW = 34;  // CORDIC x/y datapath
  localparam int ZW = 34;  // CORDIC angle datapath
  localparam int TW = 32;  // sine/cosine handed to the back end
  localparam int RW = 34;  // products and matrix entries
  localparam int DW = 22;  // |scale| * 64

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  localparam int DIV_STEPS = RW;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  localparam logic signed [CW-1:0] GAIN_Q30   = 34'sd652032874;
  localparam logic signed [35:0]   PI_Q30     = 36'sd3373259426;
  localparam logic signed [35:0]   HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0]   TWO_PI_Q30 = 36'sd6746518852;

  localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  localparam logic CMD_MODEL  = 1'b0;
  localparam logic CMD_NORMAL = 1'b1;

  localparam logic [1:0] COL_TRANS       = 2'd3;
  localparam logic [1:0] COL_LAST_NORMAL = 2'd2;

  localparam logic signed [31:0] Q16_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cord_t;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } pay_t;

  // lane 0: angle Y (s1,c1), lane 1: angle X (s2,c2), lane 2: angle Z (s3,c3)
  typedef struct packed {
    pay_t                 pay;
    logic [2:0][TW-1:0]   sn;
    logic [2:0][TW-1:0]   cs;
  } ent_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_MODEL,
    E_DSTART,
    E_DWAIT
  } emit_e;

  function automatic logic signed [RW-1:0] mul30(logic signed [RW-1:0] a,
                                                logic signed [RW-1:0] b);
    logic signed [2*RW-1:0] p;
    p = a * b;
    return p[RW+29:30];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(Q16_MAX)) r = Q16_MAX;
    else if (v < 64'(Q16_MIN)) r = Q16_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> design/euler_scale_translate_matrix.sv
// channel   | direction | handshake          | payload
// request   | in        | start / busy       | command, angles, scales, offsets
// column    | out       | valid_o strobe     | column_index, elem_0..2, last_column, zero_scale
//
// A request is taken when start is high and busy is low; up to eight requests may be
// in flight (CORDIC pipe plus queue), after which busy holds further requests off.
// Sine/cosine come from the CORDIC pipe; back-end stages A, B and C form the matrix.
// Model matrix: one column per cycle from the emitter.
// Normal matrix: the serial dividers set the pace, each column waiting for its divisions.
// Reset is asynchronous and empties pipe and queue; results cannot be stalled.
module euler_scale_translate_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic signed [15:0] angle_x_i,
  input  logic signed [15:0] angle_y_i,
  input  logic signed [15:0] angle_z_i,
  input  logic signed [15:0] scale_x_i,
  input  logic signed [15:0] scale_y_i,
  input  logic signed [15:0] scale_z_i,
  input  logic signed [31:0] offset_x_i,
  input  logic signed [31:0] offset_y_i,
  input  logic signed [31:0] offset_z_i,
  output logic               valid_o,
  output logic [1:0]         column_index_o,
  output logic signed [31:0] elem_0_o,
  output logic signed [31:0] elem_1_o,
  output logic signed [31:0] elem_2_o,
  output logic               last_column_o,
  output logic               zero_scale_o
);

  estm_pkg::pay_t pay;
  estm_pkg::ent_t push_data, pop_data;
  logic acc, push, pop, empty;

  assign acc = start && !busy;

  always_comb begin
    pay.cmd      = command_i;
    pay.scale_x  = scale_x_i;
    pay.scale_y  = scale_y_i;
    pay.scale_z  = scale_z_i;
    pay.offset_x = offset_x_i;
    pay.offset_y = offset_y_i;
    pay.offset_z = offset_z_i;
  end

  estm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .angle_x_i (angle_x_i),
    .angle_y_i (angle_y_i),
    .angle_z_i (angle_z_i),
    .pay_i     (pay),
    .pop_i     (pop),
    .busy_o    (busy),
    .push_o    (push),
    .ent_o     (push_data)
  );

  estm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  estm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .ent_i          (pop_data),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .column_index_o (column_index_o),
    .elem_0_o       (elem_0_o),
    .elem_1_o       (elem_1_o),
    .elem_2_o       (elem_2_o),
    .last_column_o  (last_column_o),
    .zero_scale_o   (zero_scale_o)
  );

endmodule

>>> design/estm_fifo.sv
module estm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  estm_pkg::ent_t  data_i,
  input  logic            pop_i,
  output logic            empty_o,
  output estm_pkg::ent_t  data_o
);

  estm_pkg::ent_t mem_q [estm_pkg::FIFO_DEPTH];
  logic [estm_pkg::FIFO_AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [estm_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + estm_pkg::CNT_W'(push_i) - estm_pkg::CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < estm_pkg::CNT_W'(estm_pkg::FIFO_DEPTH)))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("request queue underflow");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != estm_pkg::CNT_W'(estm_pkg::FIFO_DEPTH))
      |-> (wp_q - rp_q == cnt_q[estm_pkg::FIFO_AW-1:0]))
    else $error("queue pointers disagree with count");

endmodule

>>> design/estm_front.sv
module estm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic signed [15:0] angle_x_i,
  input  logic signed [15:0] angle_y_i,
  input  logic signed [15:0] angle_z_i,
  input  estm_pkg::pay_t     pay_i,
  input  logic               pop_i,
  output logic               busy_o,
  output logic               push_o,
  output estm_pkg::ent_t     ent_o
);

  localparam int N = estm_pkg::CORDIC_N;

  estm_pkg::cord_t st_q [N+1][3];
  estm_pkg::cord_t nx   [N][3];
  estm_pkg::cord_t init [3];
  estm_pkg::pay_t  pay_q [N+1];
  logic [N:0]      vld_q;
  logic [estm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic signed [15:0] ang [3];

  // reduce into [-pi, pi], then fold into [-pi/2, pi/2] and flip the result
  function automatic estm_pkg::cord_t fold(logic signed [15:0] a);
    logic signed [35:0] z;
    estm_pkg::cord_t c;
    z     = {{2{a[15]}}, a, 18'b0};
    c.neg = 1'b0;
    if (z > estm_pkg::PI_Q30) z = z - estm_pkg::TWO_PI_Q30;
    else if (z < -estm_pkg::PI_Q30) z = z + estm_pkg::TWO_PI_Q30;
    if (z > estm_pkg::HALF_PI_Q30) begin
      z     = z - estm_pkg::PI_Q30;
      c.neg = 1'b1;
    end else if (z < -estm_pkg::HALF_PI_Q30) begin
      z     = z + estm_pkg::PI_Q30;
      c.neg = 1'b1;
    end
    c.x = estm_pkg::GAIN_Q30;
    c.y = '0;
    c.z = z[estm_pkg::ZW-1:0];
    return c;
  endfunction

  assign ang[0] = angle_y_i;
  assign ang[1] = angle_x_i;
  assign ang[2] = angle_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) init[k] = fold(ang[k]);
  end

  // one CORDIC micro-rotation per stage
  always_comb begin
    logic signed [estm_pkg::CW-1:0] xv, yv, dx, dy;
    logic signed [estm_pkg::ZW-1:0] zv;
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < 3; k++) begin
        xv = st_q[i][k].x;
        yv = st_q[i][k].y;
        zv = st_q[i][k].z;
        dx = yv >>> i;
        dy = xv >>> i;
        nx[i][k] = st_q[i][k];
        if (!zv[estm_pkg::ZW-1]) begin
          nx[i][k].x = xv - dx;
          nx[i][k].y = yv + dy;
          nx[i][k].z = zv - estm_pkg::ATAN_Q30[i];
        end else begin
          nx[i][k].x = xv + dx;
          nx[i][k].y = yv - dy;
          nx[i][k].z = zv + estm_pkg::ATAN_Q30[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]  <= init;
    pay_q[0] <= pay_i;
    for (int i = 0; i < N; i++) begin
      st_q[i+1]  <= nx[i];
      pay_q[i+1] <= pay_q[i];
    end
  end

  // items in the pipe plus items queued; held to the queue depth
  always_comb begin
    cnt_d = cnt_q + estm_pkg::CNT_W'(acc_i) - estm_pkg::CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else begin
      vld_q <= {vld_q[N-1:0], acc_i};
      cnt_q <= cnt_d;
    end
  end

  assign busy_o = (cnt_q == estm_pkg::CNT_W'(estm_pkg::FIFO_DEPTH));
  assign push_o = vld_q[N];

  always_comb begin
    logic signed [estm_pkg::CW-1:0] sv, cv;
    ent_o.pay = pay_q[N];
    for (int k = 0; k < 3; k++) begin
      sv = st_q[N][k].neg ? -st_q[N][k].y : st_q[N][k].y;
      cv = st_q[N][k].neg ? -st_q[N][k].x : st_q[N][k].x;
      ent_o.sn[k] = sv[estm_pkg::TW-1:0];
      ent_o.cs[k] = cv[estm_pkg::TW-1:0];
    end
  end

endmodule

>>> design/estm_div.sv
module estm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [estm_pkg::RW-1:0] num_i,
  input  logic signed [15:0]            scale_i,
  output logic                          rdy_o,
  output logic signed [estm_pkg::RW:0]  quo_o
);

  localparam int RW = estm_pkg::RW;
  localparam int DW = estm_pkg::DW;

  logic                        run_q;
  logic [estm_pkg::DIV_CW-1:0] cnt_q;
  logic [DW-1:0]               rem_q, dv_q;
  logic [RW-1:0]               q_q;
  logic                        neg_q;
  logic [DW:0]                 rs;
  logic                        bit_v;
  logic [DW:0]                 rs_sub;
  logic [RW-1:0]               num_mag;
  logic [15:0]                 sc_mag;

  assign num_mag = num_i[RW-1] ? RW'(-num_i) : RW'(num_i);
  assign sc_mag  = scale_i[15] ? 16'(-scale_i) : 16'(scale_i);

  // restoring division, one quotient bit per cycle
  always_comb begin
    rs     = {rem_q, q_q[RW-1]};
    rs_sub = rs - {1'b0, dv_q};
    bit_v  = (rs >= {1'b0, dv_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == estm_pkg::DIV_CW'(estm_pkg::DIV_STEPS - 1)) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_mag;
      dv_q  <= {sc_mag, 6'b0};
      rem_q <= '0;
      neg_q <= num_i[RW-1] ^ scale_i[15];
    end else if (run_q) begin
      rem_q <= bit_v ? rs_sub[DW-1:0] : rs[DW-1:0];
      q_q   <= {q_q[RW-2:0], bit_v};
    end
  end

  assign rdy_o = !run_q;
  assign quo_o = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

>>> design/estm_back.sv
module estm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  estm_pkg::ent_t     ent_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic [1:0]         column_index_o,
  output logic signed [31:0] elem_0_o,
  output logic signed [31:0] elem_1_o,
  output logic signed [31:0] elem_2_o,
  output logic               last_column_o,
  output logic               zero_scale_o
);

  localparam int RW = estm_pkg::RW;

  // stage A: queue entry, stage B: first products, stage C: rotation matrix
  estm_pkg::ent_t     a_q;
  logic               a_vld_q, b_vld_q, c_vld_q;
  estm_pkg::pay_t     b_pay_q, c_pay_q, e_pay_q;
  logic signed [RW-1:0] b_m_q [10];
  logic signed [RW-1:0] b_s2_q, b_s3_q;
  logic signed [RW-1:0] c_r_q [3][3];
  logic signed [RW-1:0] e_r_q [3][3];
  logic signed [RW-1:0] m_d [10];
  logic signed [RW-1:0] r_d [3][3];

  estm_pkg::emit_e st_q, st_d;
  logic [1:0] col_q;

  logic a_free, a_move, b_free, b_move, c_free;
  logic take, fin, emit, div_start, div_done;
  logic [2:0] lane_rdy;
  logic signed [RW:0]   quo [3];
  logic signed [RW-1:0] rc [3];
  logic signed [15:0]   sc;
  logic signed [31:0]   el [3];
  logic signed [RW+15:0] mp [3];

  assign c_free = !c_vld_q || take;
  assign b_move = b_vld_q && c_free;
  assign b_free = !b_vld_q || b_move;
  assign a_move = a_vld_q && b_free;
  assign a_free = !a_vld_q || a_move;
  assign pop_o  = !empty_i && a_free;

  always_comb begin
    logic signed [RW-1:0] s1, c1, s2, c2, s3, c3;
    s1 = RW'($signed(a_q.sn[0]));
    c1 = RW'($signed(a_q.cs[0]));
    s2 = RW'($signed(a_q.sn[1]));
    c2 = RW'($signed(a_q.cs[1]));
    s3 = RW'($signed(a_q.sn[2]));
    c3 = RW'($signed(a_q.cs[2]));
    m_d[0] = estm_pkg::mul30(c1, c3);
    m_d[1] = estm_pkg::mul30(s1, s2);
    m_d[2] = estm_pkg::mul30(c2, s3);
    m_d[3] = estm_pkg::mul30(c1, s2);
    m_d[4] = estm_pkg::mul30(c3, s1);
    m_d[5] = estm_pkg::mul30(c1, s3);
    m_d[6] = estm_pkg::mul30(c2, c3);
    m_d[7] = estm_pkg::mul30(s1, s3);
    m_d[8] = estm_pkg::mul30(c2, s1);
    m_d[9] = estm_pkg::mul30(c1, c2);
  end

  // r[col][row]
  always_comb begin
    r_d[0][0] = b_m_q[0] + estm_pkg::mul30(b_m_q[1], b_s3_q);
    r_d[0][1] = b_m_q[2];
    r_d[0][2] = estm_pkg::mul30(b_m_q[3], b_s3_q) - b_m_q[4];
    r_d[1][0] = estm_pkg::mul30(b_m_q[4], b_s2_q) - b_m_q[5];
    r_d[1][1] = b_m_q[6];
    r_d[1][2] = estm_pkg::mul30(b_m_q[0], b_s2_q) + b_m_q[7];
    r_d[2][0] = b_m_q[8];
    r_d[2][1] = -b_s2_q;
    r_d[2][2] = b_m_q[9];
  end

  always_ff @(posedge clk_i) begin
    if (a_free) a_q <= ent_i;
    if (a_move) begin
      b_pay_q <= a_q.pay;
      b_m_q   <= m_d;
      b_s2_q  <= RW'($signed(a_q.sn[1]));
      b_s3_q  <= RW'($signed(a_q.sn[2]));
    end
    if (b_move) begin
      c_pay_q <= b_pay_q;
      c_r_q   <= r_d;
    end
    if (take) begin
      e_pay_q <= c_pay_q;
      e_r_q   <= c_r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_free) a_vld_q <= pop_o;
      if (b_free) b_vld_q <= a_move;
      if (c_free) c_vld_q <= b_move;
    end
  end

  // column emitter
  assign div_done = &lane_rdy;
  assign fin = ((st_q == estm_pkg::E_MODEL) && (col_q == estm_pkg::COL_TRANS)) ||
               ((st_q == estm_pkg::E_DWAIT) && div_done &&
                (col_q == estm_pkg::COL_LAST_NORMAL));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      estm_pkg::E_IDLE: begin
        if (c_vld_q)
          st_d = (c_pay_q.cmd == estm_pkg::CMD_NORMAL) ? estm_pkg::E_DSTART
                                                       : estm_pkg::E_MODEL;
      end
      estm_pkg::E_MODEL: begin
        if (fin) begin
          if (!c_vld_q) st_d = estm_pkg::E_IDLE;
          else st_d = (c_pay_q.cmd == estm_pkg::CMD_NORMAL) ? estm_pkg::E_DSTART
                                                            : estm_pkg::E_MODEL;
        end
      end
      estm_pkg::E_DSTART: st_d = estm_pkg::E_DWAIT;
      estm_pkg::E_DWAIT: begin
        if (fin) begin
          if (!c_vld_q) st_d = estm_pkg::E_IDLE;
          else st_d = (c_pay_q.cmd == estm_pkg::CMD_NORMAL) ? estm_pkg::E_DSTART
                                                            : estm_pkg::E_MODEL;
        end else if (div_done) begin
          st_d = estm_pkg::E_DSTART;
        end
      end
      default: st_d = estm_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    take      = 1'b0;
    emit      = 1'b0;
    div_start = 1'b0;
    unique case (st_q)
      estm_pkg::E_IDLE:   take = c_vld_q;
      estm_pkg::E_MODEL: begin
        emit = 1'b1;
        take = c_vld_q && fin;
      end
      estm_pkg::E_DSTART: div_start = 1'b1;
      estm_pkg::E_DWAIT: begin
        emit = div_done;
        take = c_vld_q && fin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= estm_pkg::E_IDLE;
      col_q <= '0;
    end else begin
      st_q <= st_d;
      if (take) col_q <= '0;
      else if (emit) col_q <= col_q + 1'b1;
    end
  end

  always_comb begin
    case (col_q)
      2'd0: begin
        rc = e_r_q[0];
        sc = e_pay_q.scale_x;
      end
      2'd1: begin
        rc = e_r_q[1];
        sc = e_pay_q.scale_y;
      end
      2'd2: begin
        rc = e_r_q[2];
        sc = e_pay_q.scale_z;
      end
      default: begin
        rc = e_r_q[0];
        sc = '0;
      end
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    estm_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (rc[k]),
      .scale_i (sc),
      .rdy_o   (lane_rdy[k]),
      .quo_o   (quo[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mp[k] = rc[k] * sc;
      if (col_q == estm_pkg::COL_TRANS) begin
        el[k] = '0;
      end else if (e_pay_q.cmd == estm_pkg::CMD_MODEL) begin
        el[k] = estm_pkg::sat32(64'(mp[k] >>> 22));
      end else if (sc == '0) begin
        // zero divisor: saturate by the sign of the rotation entry
        if (rc[k] > 0) el[k] = estm_pkg::Q16_MAX;
        else if (rc[k] < 0) el[k] = estm_pkg::Q16_MIN;
        else el[k] = '0;
      end else begin
        el[k] = estm_pkg::sat32(64'(quo[k]));
      end
    end
    if (col_q == estm_pkg::COL_TRANS) begin
      el[0] = e_pay_q.offset_x;
      el[1] = e_pay_q.offset_y;
      el[2] = e_pay_q.offset_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= emit;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      column_index_o <= col_q;
      elem_0_o       <= el[0];
      elem_1_o       <= el[1];
      elem_2_o       <= el[2];
      last_column_o  <= fin;
      zero_scale_o   <= (e_pay_q.cmd == estm_pkg::CMD_NORMAL) && (sc == '0);
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 400000;
  localparam int N_RANDOM = 320;

  typedef struct {
    logic               cmd;
    logic signed [15:0] ax, ay, az;
    logic signed [15:0] sx, sy, sz;
    logic signed [31:0] ox, oy, oz;
  } req_t;

  typedef struct {
    logic [1:0]  idx;
    logic [31:0] e0, e1, e2;
    logic        last, zs;
  } column_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start;
  logic               busy;
  logic               command_i;
  logic signed [15:0] angle_x_i, angle_y_i, angle_z_i;
  logic signed [15:0] scale_x_i, scale_y_i, scale_z_i;
  logic signed [31:0] offset_x_i, offset_y_i, offset_z_i;
  logic               valid_o;
  logic [1:0]         column_index_o;
  logic signed [31:0] elem_0_o, elem_1_o, elem_2_o;
  logic               last_column_o, zero_scale_o;

  req_t    req_q[$];
  column_t column_q[$];
  req_t    cur_req;
  int      n_accepted = 0;
  int      cycles = 0;
  bit      failed = 1'b0;

  longint atan_tab[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  euler_scale_translate_matrix DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic cordic_sincos(input logic signed [15:0] ang, output longint sn,
                               output longint cs);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang) * 262144;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd3373259426) z -= 64'sd6746518852;
    else if (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < estm_pkg::CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // expected columns of one request, pushed in emission order
  task automatic form_matrix(input req_t rq);
    longint s1, c1, s2, c2, s3, c3, e;
    longint rot[3][3];
    longint sc[3];
    longint off[3];
    column_t col;
    int ncols;
    cordic_sincos(rq.ay, s1, c1);
    cordic_sincos(rq.ax, s2, c2);
    cordic_sincos(rq.az, s3, c3);
    sc = '{longint'(rq.sx), longint'(rq.sy), longint'(rq.sz)};
    off = '{longint'(rq.ox), longint'(rq.oy), longint'(rq.oz)};
    rot[0][0] = q30_mul(c1, c3) + q30_mul(q30_mul(s1, s2), s3);
    rot[0][1] = q30_mul(c2, s3);
    rot[0][2] = q30_mul(q30_mul(c1, s2), s3) - q30_mul(c3, s1);
    rot[1][0] = q30_mul(q30_mul(c3, s1), s2) - q30_mul(c1, s3);
    rot[1][1] = q30_mul(c2, c3);
    rot[1][2] = q30_mul(q30_mul(c1, c3), s2) + q30_mul(s1, s3);
    rot[2][0] = q30_mul(c2, s1);
    rot[2][1] = -s2;
    rot[2][2] = q30_mul(c1, c2);
    ncols = (rq.cmd == estm_pkg::CMD_NORMAL) ? 3 : 4;
    for (int c = 0; c < ncols; c++) begin
      col.idx = c[1:0];
      for (int r = 0; r < 3; r++) begin
        if (c == 3) e = off[r];
        else if (rq.cmd == estm_pkg::CMD_MODEL) e = clamp32((rot[c][r] * sc[c]) >>> 22);
        else if (sc[c] == 0)
          e = (rot[c][r] > 0) ? 64'sd2147483647 :
              (rot[c][r] < 0) ? -64'sd2147483648 : 0;
        else e = clamp32(rot[c][r] / (sc[c] * 64));
        case (r)
          0: col.e0 = e[31:0];
          1: col.e1 = e[31:0];
          default: col.e2 = e[31:0];
        endcase
      end
      col.last = (c == ncols - 1);
      col.zs = (rq.cmd == estm_pkg::CMD_NORMAL) && (sc[c] == 0);
      column_q.push_back(col);
    end
  endtask

  function automatic req_t random_req();
    req_t rq;
    rq.cmd = 1'($urandom_range(1));
    rq.ax = 16'($urandom); rq.ay = 16'($urandom); rq.az = 16'($urandom);
    rq.sx = 16'($urandom); rq.sy = 16'($urandom); rq.sz = 16'($urandom);
    // small and zero scales reach the zero-divisor and non-saturating paths
    if ($urandom_range(3) == 0) rq.sx = 16'(int'($urandom_range(512)) - 256);
    if ($urandom_range(5) == 0) rq.sy = '0;
    if ($urandom_range(5) == 0) rq.sz = '0;
    rq.ox = $urandom; rq.oy = $urandom; rq.oz = $urandom;
    return rq;
  endfunction

  function automatic req_t make_req(logic cmd, int ax, int ay, int az,
                                    int sx, int sy, int sz, int ofs);
    req_t rq;
    rq.cmd = cmd;
    rq.ax = 16'(ax); rq.ay = 16'(ay); rq.az = 16'(az);
    rq.sx = 16'(sx); rq.sy = 16'(sy); rq.sz = 16'(sz);
    rq.ox = ofs; rq.oy = ~ofs; rq.oz = -ofs;
    return rq;
  endfunction

  // request driver: sender idles 17 %, then 53 %, then never
  always @(posedge clk_i or negedge rst_ni) begin
    int idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
      command_i <= 1'b0;
      angle_x_i <= '0; angle_y_i <= '0; angle_z_i <= '0;
      scale_x_i <= '0; scale_y_i <= '0; scale_z_i <= '0;
      offset_x_i <= '0; offset_y_i <= '0; offset_z_i <= '0;
    end else begin
      idle_pct = (n_accepted < 115) ? 17 : (n_accepted < 230) ? 53 : 0;
      if (start && !busy) begin
        form_matrix(cur_req);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = req_q.pop_front();
          start <= 1'b1;
          command_i <= cur_req.cmd;
          angle_x_i <= cur_req.ax; angle_y_i <= cur_req.ay; angle_z_i <= cur_req.az;
          scale_x_i <= cur_req.sx; scale_y_i <= cur_req.sy; scale_z_i <= cur_req.sz;
          offset_x_i <= cur_req.ox; offset_y_i <= cur_req.oy; offset_z_i <= cur_req.oz;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // column monitor
  always @(posedge clk_i) begin
    column_t want;
    if (rst_ni && valid_o) begin
      if (column_q.size() == 0) begin
        $error("unexpected column %0d", column_index_o);
        failed = 1'b1;
      end else begin
        want = column_q.pop_front();
        if (column_index_o !== want.idx) begin
          $error("column_index: expected %0d, got %0d", want.idx, column_index_o);
          failed = 1'b1;
        end
        if (elem_0_o !== want.e0) begin
          $error("elem_0: expected %h, got %h", want.e0, elem_0_o);
          failed = 1'b1;
        end
        if (elem_1_o !== want.e1) begin
          $error("elem_1: expected %h, got %h", want.e1, elem_1_o);
          failed = 1'b1;
        end
        if (elem_2_o !== want.e2) begin
          $error("elem_2: expected %h, got %h", want.e2, elem_2_o);
          failed = 1'b1;
        end
        if (last_column_o !== want.last) begin
          $error("last_column: expected %b, got %b", want.last, last_column_o);
          failed = 1'b1;
        end
        if (zero_scale_o !== want.zs) begin
          $error("zero_scale: expected %b, got %b", want.zs, zero_scale_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // extremes, angle wrap and fold boundaries near pi and pi/2, zero scales
    req_q.push_back(make_req(estm_pkg::CMD_MODEL, 0, 0, 0, 256, 256, 256, 0));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, 0, 0, 0, 256, 256, 256, 0));
    req_q.push_back(make_req(estm_pkg::CMD_MODEL, 32767, -32768, 32767, 32767, -32768,
                             32767, 32'h7fffffff));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, -32768, 32767, -32768, -32768, 32767,
                             -1, 32'h80000000));
    req_q.push_back(make_req(estm_pkg::CMD_MODEL, 12867, 12868, -12868, 1, -1, 0, 12345));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, 12868, -12867, 12867, 1, -1, 1, -1));
    req_q.push_back(make_req(estm_pkg::CMD_MODEL, 6433, 6434, -6434, -256, 512, 128,
                             65536));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, 6434, -6433, 6435, -256, 512, 128,
                             -65536));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, 0, 0, 0, 0, 0, 0, 7));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, 3000, -5000, 7000, 0, 0, 0, 9));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, 3000, -5000, 7000, 0, 300, -2, 9));
    req_q.push_back(make_req(estm_pkg::CMD_MODEL, 3000, -5000, 7000, 0, 0, 0, 9));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, 25736, -25736, 19302, 1, 1, 1, 0));
    req_q.push_back(make_req(estm_pkg::CMD_MODEL, 25736, -25736, 19302, 32767, 32767,
                             32767, 0));
    req_q.push_back(make_req(estm_pkg::CMD_MODEL, -12868, 12869, 0, -32768, -32768,
                             -32768, 32'h55aa55aa));
    req_q.push_back(make_req(estm_pkg::CMD_NORMAL, 1, -1, 2, 2, -2, 32767, 32'haa55aa55));
    for (int i = 0; i < N_RANDOM; i++) req_q.push_back(random_req());

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (req_q.size() == 0 && !start);
    wait (column_q.size() == 0);
    repeat (150) @(posedge clk_i);
    if (!failed) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
design/estm_pkg.sv
design/estm_fifo.sv
design/estm_front.sv
design/estm_div.sv
design/estm_back.sv
design/euler_scale_translate_matrix.sv
tb/testbench.sv
